// ===== hw/rtl/sadc_pkg.sv =====
// Shared types, register codes and identity bytes for the audio/data coprocessor register block.
package sadc_pkg;

  localparam logic [2:0] REVISION = 3'd2;

  // Function codes of an input beat
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Read map
  localparam logic [2:0] RD_STATUS = 3'd0;
  localparam logic [2:0] RD_DATA   = 3'd1;

  // Write map
  localparam logic [2:0] WR_SEEK0    = 3'd0;
  localparam logic [2:0] WR_SEEK1    = 3'd1;
  localparam logic [2:0] WR_SEEK2    = 3'd2;
  localparam logic [2:0] WR_SEEK3    = 3'd3;
  localparam logic [2:0] WR_TRACK_LO = 3'd4;
  localparam logic [2:0] WR_TRACK_HI = 3'd5;
  localparam logic [2:0] WR_VOLUME   = 3'd6;
  localparam logic [2:0] WR_CONTROL  = 3'd7;

  localparam logic [31:0] TRACK_HDR_BYTES = 32'd8;
  localparam logic [31:0] FRAME_BYTES     = 32'd4;
  localparam logic [15:0] NO_RESUME       = 16'hFFFF;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         addr;
    logic [7:0]         wdata;
    logic               data_ready;
    logic [7:0]         data_byte;
    logic               track_ok;
    logic [31:0]        track_loop_count;
    logic [31:0]        track_size;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic               mute;
  } sadc_in_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [31:0]        data_offset;
    logic [31:0]        play_offset;
    logic [15:0]        track_number;
    logic               playing;
  } sadc_out_t;

  // Identity string at read offsets 2..7
  function automatic logic [7:0] id_byte(input logic [2:0] addr);
    logic [7:0] b;
    case (addr)
      3'd2:    b = 8'h53;
      3'd3:    b = 8'h2D;
      3'd4:    b = 8'h4D;
      3'd5:    b = 8'h53;
      3'd6:    b = 8'h55;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/sadc_scale.sv =====
// Volume scaler: (sample * volume) / 255, truncated toward zero.
module sadc_scale (
  input  logic signed [15:0] sample_i,
  input  logic [7:0]         volume_i,
  output logic signed [15:0] scaled_o
);

  logic signed [24:0] prod;
  logic               neg;
  logic [23:0]        mag;
  logic [47:0]        acc;
  logic [15:0]        quo;

  // 1/255 ~ 0x808081 / 2^31; exact for magnitudes below 2^23
  always_comb begin
    prod = sample_i * $signed({1'b0, volume_i});
    neg  = prod[24];
    mag  = neg ? 24'(-prod) : 24'(prod);
    acc  = {24'd0, mag} + ({24'd0, mag} << 7) + ({24'd0, mag} << 15)
         + ({24'd0, mag} << 23);
    quo  = acc[46:31];
    scaled_o = neg ? $signed(16'(-quo)) : $signed(quo);
  end

endmodule

// ===== hw/rtl/streamed_audio_data_coproc_regs_top.sv =====
// Top level of the streamed audio/data coprocessor register block.
//
//  channel | signals                          | payload
//  --------+----------------------------------+--------------------------
//  in      | in_valid_i / in_ready_o          | in_data_i  (sadc_in_t)
//  out     | out_valid_o / out_ready_i        | out_data_o (sadc_out_t)
//
// One beat per cycle sustained while the output is not stalled. A beat is held in the
// input register, is decoded and updates all state in a single pass, and lands in the
// result register, which drives out_valid_o and out_data_o. Reset clears all control
// state and state registers; resume track resets to "none", error to set.
// A stall on the output holds the result register and then the input
// register; input ready drops only when both are full and out is stalled.
module streamed_audio_data_coproc_regs_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sadc_pkg::sadc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sadc_pkg::sadc_out_t out_data_o
);

  // Pipeline control
  logic               s1_valid_q, s1_valid_d;
  sadc_pkg::sadc_in_t s1_data_q;
  logic               out_valid_q, out_valid_d;
  sadc_pkg::sadc_out_t out_data_q, out_data_d;
  logic               out_free, s1_adv, in_fire;

  // Architectural state
  logic [31:0] seek_q, seek_d;
  logic [31:0] rd_pos_q, rd_pos_d;
  logic [31:0] audio_pos_q, audio_pos_d;
  logic [31:0] loop_pos_q, loop_pos_d;
  logic [31:0] audio_size_q, audio_size_d;
  logic [15:0] track_q, track_d;
  logic [7:0]  volume_q, volume_d;
  logic [15:0] res_track_q, res_track_d;
  logic [31:0] res_pos_q, res_pos_d;
  logic        error_q, error_d;
  logic        play_q, play_d;
  logic        repeat_q, repeat_d;

  logic signed [15:0] left_scaled, right_scaled;
  logic [31:0]        loop_calc;
  logic               frame_play;
  logic [7:0]         rdata;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  sadc_scale u_scale_l (
    .sample_i (s1_data_q.sample_left),
    .volume_i (volume_q),
    .scaled_o (left_scaled)
  );

  sadc_scale u_scale_r (
    .sample_i (s1_data_q.sample_right),
    .volume_i (volume_q),
    .scaled_o (right_scaled)
  );

  // Next state of the register file for the beat in the input register
  always_comb begin
    seek_d       = seek_q;
    rd_pos_d     = rd_pos_q;
    audio_pos_d  = audio_pos_q;
    loop_pos_d   = loop_pos_q;
    audio_size_d = audio_size_q;
    track_d      = track_q;
    volume_d     = volume_q;
    res_track_d  = res_track_q;
    res_pos_d    = res_pos_q;
    error_d      = error_q;
    play_d       = play_q;
    repeat_d     = repeat_q;
    rdata        = 8'd0;
    frame_play   = 1'b0;
    loop_calc    = sadc_pkg::TRACK_HDR_BYTES + {s1_data_q.track_loop_count[29:0], 2'b00};

    if (s1_adv) begin
      unique case (s1_data_q.func)
        sadc_pkg::FUNC_READ: begin
          unique case (s1_data_q.addr)
            sadc_pkg::RD_STATUS:
              rdata = {2'b00, repeat_q, play_q, error_q, sadc_pkg::REVISION};
            sadc_pkg::RD_DATA: begin
              if (s1_data_q.data_ready) begin
                rdata    = s1_data_q.data_byte;
                rd_pos_d = rd_pos_q + 32'd1;
              end
            end
            default: rdata = sadc_pkg::id_byte(s1_data_q.addr);
          endcase
        end
        sadc_pkg::FUNC_WRITE: begin
          unique case (s1_data_q.addr)
            sadc_pkg::WR_SEEK0: seek_d[7:0]   = s1_data_q.wdata;
            sadc_pkg::WR_SEEK1: seek_d[15:8]  = s1_data_q.wdata;
            sadc_pkg::WR_SEEK2: seek_d[23:16] = s1_data_q.wdata;
            sadc_pkg::WR_SEEK3: begin
              seek_d[31:24] = s1_data_q.wdata;
              rd_pos_d      = {s1_data_q.wdata, seek_q[23:0]};
            end
            sadc_pkg::WR_TRACK_LO: track_d[7:0] = s1_data_q.wdata;
            sadc_pkg::WR_TRACK_HI: begin
              // Track open
              track_d     = {s1_data_q.wdata, track_q[7:0]};
              play_d      = 1'b0;
              repeat_d    = 1'b0;
              audio_pos_d = sadc_pkg::TRACK_HDR_BYTES;
              if (track_d == res_track_q) begin
                audio_pos_d = res_pos_q;
                res_track_d = sadc_pkg::NO_RESUME;
                res_pos_d   = 32'd0;
              end
              if (s1_data_q.track_ok) begin
                loop_pos_d   = (loop_calc > s1_data_q.track_size) ?
                               sadc_pkg::TRACK_HDR_BYTES : loop_calc;
                audio_size_d = s1_data_q.track_size;
                error_d      = 1'b0;
              end else begin
                error_d = 1'b1;
              end
            end
            sadc_pkg::WR_VOLUME: volume_d = s1_data_q.wdata;
            sadc_pkg::WR_CONTROL: begin
              if (!error_q) begin
                play_d   = s1_data_q.wdata[0];
                repeat_d = s1_data_q.wdata[1];
                if (!s1_data_q.wdata[0] && s1_data_q.wdata[2]) begin
                  res_track_d = track_q;
                  res_pos_d   = audio_pos_q;
                end
              end
            end
            default: ;
          endcase
        end
        sadc_pkg::FUNC_TICK: begin
          if (play_q) begin
            if (error_q) begin
              play_d = 1'b0;
            end else if (audio_pos_q >= audio_size_q) begin
              // End of track: loop or stop
              if (!repeat_q) begin
                play_d      = 1'b0;
                audio_pos_d = sadc_pkg::TRACK_HDR_BYTES;
              end else begin
                audio_pos_d = loop_pos_q;
              end
            end else begin
              audio_pos_d = audio_pos_q + sadc_pkg::FRAME_BYTES;
              frame_play  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result beat and pipeline occupancy
  always_comb begin
    s1_valid_d  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    out_data_d  = out_data_q;
    if (s1_adv) begin
      out_data_d.read_data    = rdata;
      out_data_d.left_out     = (frame_play && !s1_data_q.mute) ? left_scaled : 16'sd0;
      out_data_d.right_out    = (frame_play && !s1_data_q.mute) ? right_scaled : 16'sd0;
      out_data_d.data_offset  = rd_pos_d;
      out_data_d.play_offset  = audio_pos_d;
      out_data_d.track_number = track_d;
      out_data_d.playing      = play_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      seek_q       <= 32'd0;
      rd_pos_q     <= 32'd0;
      audio_pos_q  <= 32'd0;
      loop_pos_q   <= 32'd0;
      audio_size_q <= 32'd0;
      track_q      <= 16'd0;
      volume_q     <= 8'd0;
      res_track_q  <= sadc_pkg::NO_RESUME;
      res_pos_q    <= 32'd0;
      error_q      <= 1'b1;
      play_q       <= 1'b0;
      repeat_q     <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      seek_q       <= seek_d;
      rd_pos_q     <= rd_pos_d;
      audio_pos_q  <= audio_pos_d;
      loop_pos_q   <= loop_pos_d;
      audio_size_q <= audio_size_d;
      track_q      <= track_d;
      volume_q     <= volume_d;
      res_track_q  <= res_track_d;
      res_pos_q    <= res_pos_d;
      error_q      <= error_d;
      play_q       <= play_d;
      repeat_q     <= repeat_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    out_data_q <= out_data_d;
  end

  // Error state never coexists with play
  assert property (@(posedge clk_i) disable iff (!rst_ni) error_q |-> !play_q)
    else $error("play set while in error");

  // A held beat in the input register is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("input beat lost");

  // Nonzero samples only leave with play still set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.left_out != 16'sd0 || out_data_o.right_out != 16'sd0))
    |-> out_data_o.playing)
    else $error("sample output while stopped");

  // Result register only loads from a live input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_valid_q && !out_valid_q) |=> !out_valid_q)
    else $error("result without beat");

endmodule

// ===== tb/streamed_audio_data_coproc_regs_top_tb.sv =====
// Self-checking testbench for the streamed audio/data coprocessor register block.
module streamed_audio_data_coproc_regs_top_tb;

  // Function code 3 is not decoded by the block; it must leave all state alone.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Control register bits
  localparam logic [7:0] CTRL_PLAY   = 8'h01;
  localparam logic [7:0] CTRL_REPEAT = 8'h02;
  localparam logic [7:0] CTRL_RESUME = 8'h04;

  localparam int VOL_FULL_SCALE   = 255;
  localparam int MAX_IDLE         = 11;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int RANDOM_BEATS     = 1800;
  localparam int DRAIN_CYCLES     = 8;
  // Slowest legal run is roughly 1900 beats with maximal idling on both sides plus one long hold.
  localparam int CYCLE_LIMIT      = 400000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sadc_pkg::sadc_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sadc_pkg::sadc_out_t out_data;

  // 4 time unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  streamed_audio_data_coproc_regs_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the register state, advanced once per accepted input beat.
  // ---------------------------------------------------------------------------
  logic [31:0] seek_q, data_pos_q, audio_pos_q, loop_pos_q, audio_size_q, resume_pos_q;
  logic [15:0] track_q, resume_track_q;
  logic [7:0]  volume_q;
  logic        error_q, play_q, repeat_q;

  // Register responses predicted for beats already taken by the block, oldest first.
  sadc_pkg::sadc_out_t reg_responses_q[$];

  int  mismatch_count = 0;
  int  beats_sent     = 0;
  bit  idle_on        = 1'b1;  // cleared for stretches with no idling on either side
  int  hold_requests  = 0;     // bumped by a test to ask the receiver for a long hold

  task automatic reset_shadow();
    seek_q         = '0;
    data_pos_q     = '0;
    audio_pos_q    = '0;
    loop_pos_q     = '0;
    audio_size_q   = '0;
    track_q        = '0;
    volume_q       = '0;
    resume_track_q = sadc_pkg::NO_RESUME;
    resume_pos_q   = '0;
    error_q        = 1'b1;   // no track open after reset
    play_q         = 1'b0;
    repeat_q       = 1'b0;
  endtask

  // Applies one beat to the shadow registers and returns the response it causes.
  function automatic sadc_pkg::sadc_out_t apply_bus_beat(input sadc_pkg::sadc_in_t b);
    sadc_pkg::sadc_out_t r;
    logic [31:0]         lp;
    int                  vol;
    int                  lprod;
    int                  rprod;
    r   = '0;
    vol = volume_q;
    case (b.func)
      sadc_pkg::FUNC_READ: begin
        if (b.addr == sadc_pkg::RD_STATUS) begin
          // busy bits always read as zero
          r.read_data = {2'b00, repeat_q, play_q, error_q, sadc_pkg::REVISION};
        end else if (b.addr == sadc_pkg::RD_DATA) begin
          // a read past the end of data returns 0 and holds the offset
          if (b.data_ready) begin
            r.read_data = b.data_byte;
            data_pos_q  = data_pos_q + 32'd1;
          end
        end else begin
          // identity string, one character per address
          case (b.addr)
            3'd2:    r.read_data = 8'h53;
            3'd3:    r.read_data = 8'h2D;
            3'd4:    r.read_data = 8'h4D;
            3'd5:    r.read_data = 8'h53;
            3'd6:    r.read_data = 8'h55;
            default: r.read_data = 8'h31;
          endcase
        end
      end
      sadc_pkg::FUNC_WRITE: begin
        case (b.addr)
          sadc_pkg::WR_SEEK0: seek_q[7:0]   = b.wdata;
          sadc_pkg::WR_SEEK1: seek_q[15:8]  = b.wdata;
          sadc_pkg::WR_SEEK2: seek_q[23:16] = b.wdata;
          sadc_pkg::WR_SEEK3: begin
            seek_q[31:24] = b.wdata;
            data_pos_q    = seek_q;
          end
          sadc_pkg::WR_TRACK_LO: track_q[7:0] = b.wdata;
          sadc_pkg::WR_TRACK_HI: begin
            // opening a track always stops playback
            track_q[15:8] = b.wdata;
            play_q        = 1'b0;
            repeat_q      = 1'b0;
            audio_pos_q   = sadc_pkg::TRACK_HDR_BYTES;
            if (track_q == resume_track_q) begin
              audio_pos_q    = resume_pos_q;
              resume_track_q = sadc_pkg::NO_RESUME;
              resume_pos_q   = '0;
            end
            if (b.track_ok) begin
              // loop offset wraps mod 2^32; past the end it falls back to the header
              lp = sadc_pkg::TRACK_HDR_BYTES + b.track_loop_count * sadc_pkg::FRAME_BYTES;
              if (lp > b.track_size) lp = sadc_pkg::TRACK_HDR_BYTES;
              loop_pos_q   = lp;
              audio_size_q = b.track_size;
              error_q      = 1'b0;
            end else begin
              error_q = 1'b1;
            end
          end
          sadc_pkg::WR_VOLUME: volume_q = b.wdata;
          default: begin
            // control is dead while no track is open
            if (!error_q) begin
              play_q   = |(b.wdata & CTRL_PLAY);
              repeat_q = |(b.wdata & CTRL_REPEAT);
              if (!play_q && |(b.wdata & CTRL_RESUME)) begin
                resume_track_q = track_q;
                resume_pos_q   = audio_pos_q;
              end
            end
          end
        endcase
      end
      sadc_pkg::FUNC_TICK: begin
        if (play_q) begin
          if (error_q) begin
            play_q = 1'b0;
          end else if (audio_pos_q >= audio_size_q) begin
            // end of track: loop or stop, silent frame either way
            if (!repeat_q) begin
              play_q      = 1'b0;
              audio_pos_q = sadc_pkg::TRACK_HDR_BYTES;
            end else begin
              audio_pos_q = loop_pos_q;
            end
          end else begin
            audio_pos_q = audio_pos_q + sadc_pkg::FRAME_BYTES;
            if (!b.mute) begin
              // signed division truncates toward zero
              lprod       = int'($signed(b.sample_left)) * vol;
              rprod       = int'($signed(b.sample_right)) * vol;
              lprod       = lprod / VOL_FULL_SCALE;
              rprod       = rprod / VOL_FULL_SCALE;
              r.left_out  = lprod[15:0];
              r.right_out = rprod[15:0];
            end
          end
        end
      end
      default: ;
    endcase
    r.data_offset  = data_pos_q;
    r.play_offset  = audio_pos_q;
    r.track_number = track_q;
    r.playing      = play_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] pick_sample();
    logic [15:0] s;
    case ($urandom_range(0, 7))
      0:       s = 16'h8000;
      1:       s = 16'h7FFF;
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  // Beat with the given bus fields and random storage-side inputs. Track sizes are
  // kept small most of the time so playback reaches the end of the track.
  function automatic sadc_pkg::sadc_in_t env_beat(input logic [1:0] f, input logic [2:0] a,
                                                  input logic [7:0] w);
    sadc_pkg::sadc_in_t b;
    b.func       = f;
    b.addr       = a;
    b.wdata      = w;
    b.data_ready = ($urandom_range(0, 7) != 0);
    b.data_byte  = 8'($urandom);
    b.track_ok   = ($urandom_range(0, 5) != 0);
    case ($urandom_range(0, 15))
      0, 1:    b.track_size = $urandom;
      2:       b.track_size = sadc_pkg::TRACK_HDR_BYTES;
      default: b.track_size = $urandom_range(0, 96);
    endcase
    case ($urandom_range(0, 15))
      0, 1:    b.track_loop_count = $urandom;
      2:       b.track_loop_count = 32'h3FFF_FFFE;  // loop offset wraps to 0
      3:       b.track_loop_count = 32'h3FFF_FFFF;  // loop offset wraps to 4
      default: b.track_loop_count = $urandom_range(0, 24);
    endcase
    b.sample_left  = pick_sample();
    b.sample_right = pick_sample();
    b.mute         = ($urandom_range(0, 7) == 0);
    return b;
  endfunction

  // Offers one beat after a random gap and records its predicted response once taken.
  task automatic send_beat(input sadc_pkg::sadc_in_t b);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    reg_responses_q.push_back(apply_bus_beat(b));
    beats_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_beat(env_beat(sadc_pkg::FUNC_TICK, 3'($urandom), 8'($urandom)));
  endtask

  // ---------------------------------------------------------------------------
  // Response checking and receiver stalls
  // ---------------------------------------------------------------------------
  sadc_pkg::sadc_out_t want_r;
  int                  out_stall = 0;
  int                  hold_left = 0;
  int                  hold_served = 0;

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reg_responses_q.size() == 0) begin
          $display("%0t: unexpected response beat: expected none, actual %0h",
                   $time, out_data);
          mismatch_count++;
        end else begin
          want_r = reg_responses_q.pop_front();
          check_field("read_data",    32'(want_r.read_data),    32'(out_data.read_data));
          check_field("left_out",     32'(want_r.left_out),     32'(out_data.left_out));
          check_field("right_out",    32'(want_r.right_out),    32'(out_data.right_out));
          check_field("data_offset",  want_r.data_offset,       out_data.data_offset);
          check_field("play_offset",  want_r.play_offset,       out_data.play_offset);
          check_field("track_number", 32'(want_r.track_number), 32'(out_data.track_number));
          check_field("playing",      32'(want_r.playing),      32'(out_data.playing));
        end
        out_stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      // long hold asked by a test, counted here so the sender keeps pushing meanwhile
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Status with error set, data read with no data, control and tick while no track
  // is open, and the undecoded function code.
  task automatic test_reset_state();
    sadc_pkg::sadc_in_t b;
    send_beat(env_beat(sadc_pkg::FUNC_READ, sadc_pkg::RD_STATUS, 8'h00));
    b = env_beat(sadc_pkg::FUNC_READ, sadc_pkg::RD_DATA, 8'h00);
    b.data_ready = 1'b0;
    send_beat(b);
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_CONTROL, CTRL_PLAY | CTRL_REPEAT));
    send_beat(env_beat(sadc_pkg::FUNC_TICK, 3'd0, 8'h00));
    send_beat(env_beat(FUNC_UNUSED, 3'h7, 8'hFF));
  endtask

  task automatic test_identity_bytes();
    for (int a = 2; a < 8; a++) send_beat(env_beat(sadc_pkg::FUNC_READ, 3'(a), 8'h00));
  endtask

  // Seek to the last byte and read it: the offset wraps to zero.
  task automatic test_seek_wrap();
    sadc_pkg::sadc_in_t b;
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_SEEK0, 8'hFF));
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_SEEK1, 8'hFF));
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_SEEK2, 8'hFF));
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_SEEK3, 8'hFF));
    b = env_beat(sadc_pkg::FUNC_READ, sadc_pkg::RD_DATA, 8'h00);
    b.data_ready = 1'b1;
    b.data_byte  = 8'hFF;
    send_beat(b);
  endtask

  // Track 0xFFFF matches the reset resume slot; the failed open keeps the error.
  // Track 1 then opens with a loop count that wraps the loop offset down to 4.
  task automatic test_track_open();
    sadc_pkg::sadc_in_t b;
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_TRACK_LO, 8'hFF));
    b = env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_TRACK_HI, 8'hFF);
    b.track_ok = 1'b0;
    send_beat(b);
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_TRACK_LO, 8'h01));
    b = env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_TRACK_HI, 8'h00);
    b.track_ok         = 1'b1;
    b.track_size       = 32'd12;
    b.track_loop_count = 32'h3FFF_FFFF;
    send_beat(b);
  endtask

  // Full volume on extreme samples, loop at track end, muted frame, then stop with
  // resume at offset 12.
  task automatic test_playback_loop();
    sadc_pkg::sadc_in_t b;
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_VOLUME, 8'hFF));
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_CONTROL, CTRL_PLAY | CTRL_REPEAT));
    b = env_beat(sadc_pkg::FUNC_TICK, 3'd0, 8'h00);
    b.sample_left  = 16'h8000;
    b.sample_right = 16'h7FFF;
    b.mute         = 1'b0;
    send_beat(b);                                             // 8 -> 12
    send_beat(env_beat(sadc_pkg::FUNC_TICK, 3'd0, 8'h00));    // end reached, back to 4
    b = env_beat(sadc_pkg::FUNC_TICK, 3'd0, 8'h00);
    b.mute = 1'b1;
    send_beat(b);                                             // 4 -> 8, silent
    send_beat(env_beat(sadc_pkg::FUNC_TICK, 3'd0, 8'h00));    // 8 -> 12
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_CONTROL, CTRL_RESUME));
  endtask

  // Reopening the same track restores offset 12; without repeat the end stops play.
  task automatic test_resume_and_stop();
    sadc_pkg::sadc_in_t b;
    b = env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_TRACK_HI, 8'h00);
    b.track_ok         = 1'b1;
    b.track_size       = 32'd12;
    b.track_loop_count = 32'd0;
    send_beat(b);
    send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_CONTROL, CTRL_PLAY));
    send_beat(env_beat(sadc_pkg::FUNC_TICK, 3'd0, 8'h00));
  endtask

  // Receiver holds off for a long stretch while the sender streams back to back.
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_requests++;
    repeat (40) begin
      send_beat(env_beat(($urandom_range(0, 1) != 0) ? sadc_pkg::FUNC_TICK
                                                     : sadc_pkg::FUNC_READ,
                         3'($urandom), 8'($urandom)));
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly well-formed register sequences with random content.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic();
    sadc_pkg::sadc_in_t b;
    logic [31:0]        seek_val;
    logic [7:0]         vol;
    int                 stop_at;
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      idle_on = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          // seek, sometimes near the top so the read offset wraps, then read data
          seek_val = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                                  : $urandom;
          if ($urandom_range(0, 3) != 0)
            send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_SEEK0, seek_val[7:0]));
          if ($urandom_range(0, 3) != 0)
            send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_SEEK1, seek_val[15:8]));
          send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_SEEK2, seek_val[23:16]));
          send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_SEEK3, seek_val[31:24]));
          repeat ($urandom_range(1, 6))
            send_beat(env_beat(sadc_pkg::FUNC_READ, sadc_pkg::RD_DATA, 8'($urandom)));
        end
        2, 3, 4: begin
          // open a track from a small set, set volume, start, and play
          send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_TRACK_LO,
                             ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 3))));
          send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_TRACK_HI,
                             ($urandom_range(0, 7) == 0) ? 8'hFF : 8'h00));
          case ($urandom_range(0, 5))
            0:       vol = 8'h00;
            1:       vol = 8'hFF;
            default: vol = 8'($urandom);
          endcase
          send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_VOLUME, vol));
          b = env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_CONTROL, 8'($urandom));
          if ($urandom_range(0, 5) != 0) b.wdata = b.wdata | CTRL_PLAY;
          send_beat(b);
          repeat ($urandom_range(4, 40)) begin
            if ($urandom_range(0, 9) == 0)
              send_beat(env_beat(sadc_pkg::FUNC_READ, sadc_pkg::RD_STATUS, 8'h00));
            else send_ticks(1);
          end
        end
        5: begin
          // stop with resume, then reopen the same track and carry on
          b = env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_CONTROL, 8'($urandom));
          b.wdata = (b.wdata & ~CTRL_PLAY) | CTRL_RESUME;
          send_beat(b);
          send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_TRACK_HI, track_q[15:8]));
          send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_CONTROL,
                             CTRL_PLAY | 8'($urandom_range(0, 2))));
          send_ticks($urandom_range(1, 12));
        end
        6: begin
          repeat ($urandom_range(2, 6))
            send_beat(env_beat(sadc_pkg::FUNC_READ, 3'($urandom), 8'($urandom)));
        end
        7: begin
          // noise, the undecoded function code included
          repeat ($urandom_range(1, 4)) begin
            send_beat(env_beat(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom)));
          end
        end
        8: begin
          send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_VOLUME, 8'($urandom)));
          send_ticks($urandom_range(1, 10));
        end
        default: begin
          send_beat(env_beat(sadc_pkg::FUNC_WRITE, sadc_pkg::WR_CONTROL, 8'($urandom)));
          send_ticks($urandom_range(1, 10));
        end
      endcase
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_identity_bytes();
    test_seek_wrap();
    test_track_open();
    test_playback_loop();
    test_resume_and_stop();
    test_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    // drain: every predicted response must come out, then allow for the pipeline
    while (reg_responses_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
